>>> hw/rtl/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg: shared types and constants of the tone curve mapper
// Sample type, opcodes, register indexes, sequencer states, request structs.
// ----------------------------------------------------------------------------
package tcm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int CURVE_COUNT = 5;
   localparam int COUNT_BITS  = 9;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SAMPLE_BITS:0]   diff_type;

   localparam logic [1:0] MODE_MAP    = 2'd0;
   localparam logic [1:0] MODE_ENTRY  = 2'd1;
   localparam logic [1:0] MODE_LIMITS = 2'd2;

   localparam logic [2:0] CURVE_MASTER = 3'd0;
   localparam logic [2:0] CURVE_VALUE  = 3'd4;

   localparam logic [2:0] REG_FILM_LIKE    = 3'd0;
   localparam logic [2:0] REG_COUNT_MASTER = 3'd1;
   localparam logic [2:0] REG_COUNT_RED    = 3'd2;
   localparam logic [2:0] REG_COUNT_GREEN  = 3'd3;
   localparam logic [2:0] REG_COUNT_BLUE   = 3'd4;
   localparam logic [2:0] REG_COUNT_VALUE  = 3'd5;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 9'd33;

   // high, middle, low channel for each ordering of r, g, b
   localparam logic [1:0] SORT_ROWS [6][3] = '{
      '{2'd0, 2'd1, 2'd2}, '{2'd2, 2'd0, 2'd1}, '{2'd0, 2'd2, 2'd1},
      '{2'd1, 2'd0, 2'd2}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd2, 2'd0}
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_MASTER, ST_SORT, ST_CHAN, ST_ALPHA,
      ST_FHI, ST_FLO, ST_MID, ST_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      EV_IDLE, EV_END_READ, EV_END_DATA, EV_SCAN_FIRST, EV_SCAN_PRIME, EV_SCAN, EV_WAIT
   } ev_state_type;

   typedef enum logic [1:0] {
      IP_IDLE, IP_MUL, IP_DIV, IP_FIN
   } ip_state_type;

   typedef struct packed {
      logic                  start;
      logic [2:0]            curve;
      sample_type            v;
      logic [COUNT_BITS-1:0] count;
      sample_type            low;
      sample_type            high;
   } eval_req_type;

   typedef struct packed {
      logic       done;
      sample_type value;
   } result_type;

   typedef struct packed {
      logic       start;
      sample_type base;
      diff_type   a;
      diff_type   b;
      logic [SAMPLE_BITS:0] d;
   } interp_req_type;

   function automatic sample_type sat_sample(input logic signed [36:0] v);
      logic signed [36:0] hi;
      logic signed [36:0] lo;
      hi = 37'sd32767;
      lo = -37'sd32768;
      if (v > hi) return sample_type'(hi[SAMPLE_BITS-1:0]);
      if (v < lo) return sample_type'(lo[SAMPLE_BITS-1:0]);
      return v[SAMPLE_BITS-1:0];
   endfunction

endpackage

>>> hw/rtl/tcm_ram.sv
// ----------------------------------------------------------------------------
// tcm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1280,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tcm_interp.sv
// ----------------------------------------------------------------------------
// tcm_interp: shared interpolation unit
// base + round(a*b/d), one registered multiply then a bit-serial divide.
// ----------------------------------------------------------------------------
module tcm_interp (
   input  logic                    clock,
   input  logic                    reset,
   input  tcm_pkg::interp_req_type req,
   output tcm_pkg::result_type     rsp
);

   tcm_pkg::ip_state_type st_ff, st_in;
   logic signed [33:0]    prod_ff;
   logic [34:0]           num_ff;
   logic [16:0]           rem_ff;
   logic [16:0]           d_ff;
   logic [5:0]            cnt_ff;
   logic                  neg_ff;
   tcm_pkg::sample_type   base_ff;
   tcm_pkg::sample_type   res_ff;
   logic                  done_ff;

   logic [33:0] mag;
   logic [17:0] shifted;
   logic [18:0] trial;
   logic signed [36:0] sum;

   always_comb begin
      mag     = prod_ff[33] ? 34'(-prod_ff) : 34'(prod_ff);
      shifted = {rem_ff, num_ff[34]};
      trial   = {1'b0, shifted} - {2'b0, d_ff};
      sum     = neg_ff ? ($signed({{21{base_ff[15]}}, base_ff}) - $signed({2'b0, num_ff}))
                       : ($signed({{21{base_ff[15]}}, base_ff}) + $signed({2'b0, num_ff}));
      st_in = st_ff;
      unique case (st_ff)
         tcm_pkg::IP_IDLE: if (req.start) st_in = tcm_pkg::IP_MUL;
         tcm_pkg::IP_MUL:  st_in = tcm_pkg::IP_DIV;
         tcm_pkg::IP_DIV:  if (cnt_ff == 6'd34) st_in = tcm_pkg::IP_FIN;
         tcm_pkg::IP_FIN:  st_in = tcm_pkg::IP_IDLE;
         default:          st_in = tcm_pkg::IP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= tcm_pkg::IP_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= (st_ff == tcm_pkg::IP_FIN);
      end
      unique case (st_ff)
         tcm_pkg::IP_IDLE: begin
            prod_ff <= req.a * req.b;
            base_ff <= req.base;
            d_ff    <= req.d;
         end
         tcm_pkg::IP_MUL: begin
            neg_ff <= prod_ff[33];
            num_ff <= {1'b0, mag} + {19'b0, d_ff[16:1]};
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         tcm_pkg::IP_DIV: begin
            if (!trial[18]) begin
               rem_ff <= trial[16:0];
               num_ff <= {num_ff[33:0], 1'b1};
            end else begin
               rem_ff <= shifted[16:0];
               num_ff <= {num_ff[33:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         tcm_pkg::IP_FIN: res_ff <= tcm_pkg::sat_sample(sum);
         default: ;
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

>>> hw/rtl/tcm_curve_eval.sv
// ----------------------------------------------------------------------------
// tcm_curve_eval: curve evaluation sequencer
// Clamp check, first-match segment scan through the table RAM, interpolation.
// ----------------------------------------------------------------------------
module tcm_curve_eval #(
   parameter int TABLE_DEPTH = 256,
   localparam int AW = $clog2(tcm_pkg::CURVE_COUNT * TABLE_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tcm_pkg::eval_req_type   req,
   output tcm_pkg::result_type     rsp,
   output logic [AW-1:0]           rd_addr,
   input  logic [31:0]             rd_data,
   output tcm_pkg::interp_req_type ip_req,
   input  tcm_pkg::result_type     ip_rsp
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);

   tcm_pkg::ev_state_type st_ff;
   logic [NW-1:0]       idx_ff;
   logic [NW-1:0]       n_ff;
   logic [2:0]          curve_ff;
   tcm_pkg::sample_type v_ff;
   logic [31:0]         prev_ff;
   tcm_pkg::sample_type res_ff;
   logic                done_ff;

   logic [NW-1:0]       n_req;
   tcm_pkg::sample_type px, cx, py, cy;
   logic                hit;

   always_comb begin
      if (req.count == '0) begin
         n_req = NW'(1);
      end else if (32'(req.count) > 32'(TABLE_DEPTH)) begin
         n_req = NW'(TABLE_DEPTH);
      end else begin
         n_req = NW'(req.count);
      end
      px  = prev_ff[15:0];
      py  = prev_ff[31:16];
      cx  = rd_data[15:0];
      cy  = rd_data[31:16];
      hit = (px <= v_ff) && (v_ff <= cx);
      rd_addr = AW'(curve_ff) * AW'(TABLE_DEPTH) + AW'(idx_ff[IW-1:0]);
      ip_req.start = (st_ff == tcm_pkg::EV_SCAN) && hit && (px != cx);
      ip_req.base  = py;
      ip_req.a     = {cy[15], cy} - {py[15], py};
      ip_req.b     = {v_ff[15], v_ff} - {px[15], px};
      ip_req.d     = 17'({cx[15], cx} - {px[15], px});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= tcm_pkg::EV_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            tcm_pkg::EV_IDLE: begin
               if (req.start) begin
                  curve_ff <= req.curve;
                  v_ff     <= req.v;
                  n_ff     <= n_req;
                  if (req.v <= req.low) begin
                     idx_ff <= '0;
                     st_ff  <= tcm_pkg::EV_END_READ;
                  end else if (req.v >= req.high) begin
                     idx_ff <= n_req - NW'(1);
                     st_ff  <= tcm_pkg::EV_END_READ;
                  end else if (n_req == NW'(1)) begin
                     res_ff  <= '0;
                     done_ff <= 1'b1;
                  end else begin
                     idx_ff <= '0;
                     st_ff  <= tcm_pkg::EV_SCAN_FIRST;
                  end
               end
            end
            tcm_pkg::EV_END_READ: st_ff <= tcm_pkg::EV_END_DATA;
            tcm_pkg::EV_END_DATA: begin
               res_ff  <= cy;
               done_ff <= 1'b1;
               st_ff   <= tcm_pkg::EV_IDLE;
            end
            tcm_pkg::EV_SCAN_FIRST: begin
               idx_ff <= idx_ff + NW'(1);
               st_ff  <= tcm_pkg::EV_SCAN_PRIME;
            end
            tcm_pkg::EV_SCAN_PRIME: begin
               prev_ff <= rd_data;
               idx_ff  <= idx_ff + NW'(1);
               st_ff   <= tcm_pkg::EV_SCAN;
            end
            tcm_pkg::EV_SCAN: begin
               // rd_data holds entry idx-1, prev_ff entry idx-2
               if (hit) begin
                  if (px == cx) begin
                     res_ff  <= py;
                     done_ff <= 1'b1;
                     st_ff   <= tcm_pkg::EV_IDLE;
                  end else begin
                     st_ff <= tcm_pkg::EV_WAIT;
                  end
               end else if (idx_ff == n_ff) begin
                  res_ff  <= '0;
                  done_ff <= 1'b1;
                  st_ff   <= tcm_pkg::EV_IDLE;
               end else begin
                  prev_ff <= rd_data;
                  idx_ff  <= idx_ff + NW'(1);
               end
            end
            tcm_pkg::EV_WAIT: begin
               if (ip_rsp.done) begin
                  res_ff  <= ip_rsp.value;
                  done_ff <= 1'b1;
                  st_ff   <= tcm_pkg::EV_IDLE;
               end
            end
            default: st_ff <= tcm_pkg::EV_IDLE;
         endcase
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

>>> hw/rtl/rgb_tone_curve_mapper.sv
// ----------------------------------------------------------------------------
// rgb_tone_curve_mapper: piecewise linear tone curves on RGBA pixels
// Master curve then per-channel or film-like curves, Q3.12 samples.
// ----------------------------------------------------------------------------
//  channel | ports                          | word
//  req     | req_valid/req_ready, req_*     | command: map pixel, table entry, limits
//  rsp     | rsp_valid/rsp_ready, rsp_*     | mapped pixel
//  csr     | psel/penable/pwrite/paddr/...  | film_like and five count registers
//
//  A pixel runs seven curve evaluations in RGB mode and five in film-like
//  mode, which adds one interpolation of the middle channel when the high and
//  low channels differ. An evaluation reads the end entry when clamped,
//  gives zero for a one-entry curve inside its limits, else scans to the
//  first matching segment and, when interpolating, uses the shared multiply
//  and serial divide unit, which the middle-channel interpolation also uses.
//  Reset clears control state only; tables and limits are undefined until
//  written. A waiting result holds in the output register while the block
//  goes idle; a new pixel finishing before it is taken waits in ST_OUT.
// ----------------------------------------------------------------------------
module rgb_tone_curve_mapper #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_curve_select,
   input  logic [7:0]  req_entry_index,
   input  logic signed [15:0] req_entry_x,
   input  logic signed [15:0] req_entry_y,
   input  logic signed [15:0] req_red_in,
   input  logic signed [15:0] req_green_in,
   input  logic signed [15:0] req_blue_in,
   input  logic signed [15:0] req_alpha_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_red_out,
   output logic signed [15:0] rsp_green_out,
   output logic signed [15:0] rsp_blue_out,
   output logic signed [15:0] rsp_alpha_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(tcm_pkg::CURVE_COUNT * TABLE_DEPTH);

   tcm_pkg::top_state_type st_ff, st_in;

   // configuration
   logic                        film_ff;
   logic [tcm_pkg::COUNT_BITS-1:0] cnt_ff [tcm_pkg::CURVE_COUNT];
   tcm_pkg::sample_type         low_ff  [tcm_pkg::CURVE_COUNT];
   tcm_pkg::sample_type         high_ff [tcm_pkg::CURVE_COUNT];

   // pixel working set
   tcm_pkg::sample_type pix_ff [3];
   tcm_pkg::sample_type ch_ff  [3];
   tcm_pkg::sample_type res_ff [3];
   tcm_pkg::sample_type alpha_ff, ares_ff;
   logic [1:0]          k_ff, hi_ff, mid_ff, lo_ff;
   logic                busy_ff;

   logic                rsp_valid_ff;
   tcm_pkg::sample_type rsp_r_ff, rsp_g_ff, rsp_b_ff, rsp_a_ff;

   tcm_pkg::eval_req_type   ev_req;
   tcm_pkg::result_type     ev_rsp, ip_rsp;
   tcm_pkg::interp_req_type ev_ip, top_ip, ip_req;
   logic [AW-1:0]           rd_addr, wr_addr;
   logic [31:0]             rd_data;
   logic                    wr_en, req_fire, csr_write, eval_state;
   logic [2:0]              ev_curve, row;
   tcm_pkg::sample_type     ev_v;
   logic                    row_ok;

   function automatic logic [1:0] SORT_ROW(input logic [2:0] r, input int c);
      return tcm_pkg::SORT_ROWS[r][c];
   endfunction

   assign req_fire  = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign req_ready = (st_ff == tcm_pkg::ST_IDLE);

   // table write: drop out-of-range curve or entry
   assign wr_en   = req_fire && (req_mode == tcm_pkg::MODE_ENTRY)
                    && (32'(req_curve_select) < 32'(tcm_pkg::CURVE_COUNT))
                    && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign wr_addr = AW'(req_curve_select) * AW'(TABLE_DEPTH) + AW'(req_entry_index);

   tcm_ram #(.WIDTH(32), .DEPTH(tcm_pkg::CURVE_COUNT * TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_entry_y, req_entry_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tcm_curve_eval #(.TABLE_DEPTH(TABLE_DEPTH)) u_eval (
      .clock   (clock),
      .reset   (reset),
      .req     (ev_req),
      .rsp     (ev_rsp),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .ip_req  (ev_ip),
      .ip_rsp  (ip_rsp)
   );

   // the middle-channel interpolation borrows the same unit
   assign ip_req = (st_ff == tcm_pkg::ST_MID) ? top_ip : ev_ip;

   tcm_interp u_interp (
      .clock (clock),
      .reset (reset),
      .req   (ip_req),
      .rsp   (ip_rsp)
   );

   // channel ordering of the master-mapped pixel; equal g and b under a
   // larger r has no row
   always_comb begin
      row    = 3'd0;
      row_ok = 1'b1;
      if (ch_ff[0] > ch_ff[1]) begin
         if (ch_ff[1] > ch_ff[2])      row = 3'd0;
         else if (ch_ff[2] > ch_ff[0]) row = 3'd1;
         else if (ch_ff[2] > ch_ff[1]) row = 3'd2;
         else                          row_ok = 1'b0;
      end else if (ch_ff[0] >= ch_ff[2]) begin
         row = 3'd3;
      end else if (ch_ff[2] > ch_ff[1]) begin
         row = 3'd4;
      end else begin
         row = 3'd5;
      end
   end

   always_comb begin
      st_in      = st_ff;
      ev_curve   = tcm_pkg::CURVE_MASTER;
      ev_v       = pix_ff[k_ff];
      eval_state = 1'b0;
      top_ip.start = (st_ff == tcm_pkg::ST_MID) && !busy_ff;
      top_ip.base  = res_ff[lo_ff];
      top_ip.a     = {res_ff[hi_ff][15], res_ff[hi_ff]} - {res_ff[lo_ff][15], res_ff[lo_ff]};
      top_ip.b     = {ch_ff[mid_ff][15], ch_ff[mid_ff]} - {ch_ff[lo_ff][15], ch_ff[lo_ff]};
      top_ip.d     = 17'({ch_ff[hi_ff][15], ch_ff[hi_ff]} - {ch_ff[lo_ff][15], ch_ff[lo_ff]});
      unique case (st_ff)
         tcm_pkg::ST_IDLE: begin
            if (req_fire && (req_mode == tcm_pkg::MODE_MAP)) st_in = tcm_pkg::ST_MASTER;
         end
         tcm_pkg::ST_MASTER: begin
            eval_state = 1'b1;
            if (ev_rsp.done && (k_ff == 2'd2)) begin
               st_in = film_ff ? tcm_pkg::ST_SORT : tcm_pkg::ST_CHAN;
            end
         end
         tcm_pkg::ST_SORT: st_in = row_ok ? tcm_pkg::ST_FHI : tcm_pkg::ST_CHAN;
         tcm_pkg::ST_CHAN: begin
            eval_state = 1'b1;
            ev_curve   = 3'(k_ff) + 3'd1;
            ev_v       = ch_ff[k_ff];
            if (ev_rsp.done) begin
               if (film_ff && (k_ff == 2'd1))       st_in = tcm_pkg::ST_OUT;
               else if (!film_ff && (k_ff == 2'd2)) st_in = tcm_pkg::ST_ALPHA;
            end
         end
         tcm_pkg::ST_ALPHA: begin
            eval_state = 1'b1;
            ev_curve   = tcm_pkg::CURVE_VALUE;
            ev_v       = alpha_ff;
            if (ev_rsp.done) st_in = tcm_pkg::ST_OUT;
         end
         tcm_pkg::ST_FHI: begin
            eval_state = 1'b1;
            ev_curve   = 3'(hi_ff) + 3'd1;
            ev_v       = ch_ff[hi_ff];
            if (ev_rsp.done) st_in = tcm_pkg::ST_FLO;
         end
         tcm_pkg::ST_FLO: begin
            eval_state = 1'b1;
            ev_curve   = 3'(lo_ff) + 3'd1;
            ev_v       = ch_ff[lo_ff];
            if (ev_rsp.done) begin
               st_in = (ch_ff[hi_ff] != ch_ff[lo_ff]) ? tcm_pkg::ST_MID : tcm_pkg::ST_OUT;
            end
         end
         tcm_pkg::ST_MID: if (ip_rsp.done) st_in = tcm_pkg::ST_OUT;
         tcm_pkg::ST_OUT: if (!rsp_valid_ff) st_in = tcm_pkg::ST_IDLE;
         default: st_in = tcm_pkg::ST_IDLE;
      endcase
      ev_req.start = eval_state && !busy_ff;
      ev_req.curve = ev_curve;
      ev_req.v     = ev_v;
      ev_req.count = cnt_ff[ev_curve];
      ev_req.low   = low_ff[ev_curve];
      ev_req.high  = high_ff[ev_curve];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= tcm_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         film_ff      <= 1'b0;
         for (int i = 0; i < tcm_pkg::CURVE_COUNT; i++) cnt_ff[i] <= tcm_pkg::COUNT_RESET;
      end else begin
         st_ff <= st_in;

         if (csr_write) begin
            unique case (paddr[4:2])
               tcm_pkg::REG_FILM_LIKE:    film_ff   <= pwdata[0];
               tcm_pkg::REG_COUNT_MASTER: cnt_ff[0] <= pwdata[8:0];
               tcm_pkg::REG_COUNT_RED:    cnt_ff[1] <= pwdata[8:0];
               tcm_pkg::REG_COUNT_GREEN:  cnt_ff[2] <= pwdata[8:0];
               tcm_pkg::REG_COUNT_BLUE:   cnt_ff[3] <= pwdata[8:0];
               tcm_pkg::REG_COUNT_VALUE:  cnt_ff[4] <= pwdata[8:0];
               default: ;
            endcase
         end

         // hold busy between a start and its done
         if (ev_req.start || top_ip.start) busy_ff <= 1'b1;
         else if (ev_rsp.done || (ip_rsp.done && st_ff == tcm_pkg::ST_MID)) busy_ff <= 1'b0;

         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         unique case (st_ff)
            // start every pixel on the red channel
            tcm_pkg::ST_IDLE:   k_ff <= 2'd0;
            tcm_pkg::ST_MASTER: if (ev_rsp.done) k_ff <= (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
            tcm_pkg::ST_CHAN:   if (ev_rsp.done) k_ff <= k_ff + 2'd1;
            tcm_pkg::ST_SORT:   k_ff <= 2'd0;
            tcm_pkg::ST_OUT:    if (!rsp_valid_ff) rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end

      // payload, no reset
      if (req_fire && (req_mode == tcm_pkg::MODE_LIMITS)
          && (32'(req_curve_select) < 32'(tcm_pkg::CURVE_COUNT))) begin
         low_ff[req_curve_select]  <= req_entry_x;
         high_ff[req_curve_select] <= req_entry_y;
      end
      unique case (st_ff)
         tcm_pkg::ST_IDLE: begin
            pix_ff[0] <= req_red_in;
            pix_ff[1] <= req_green_in;
            pix_ff[2] <= req_blue_in;
            alpha_ff  <= req_alpha_in;
            ares_ff   <= req_alpha_in;
         end
         tcm_pkg::ST_MASTER: if (ev_rsp.done) ch_ff[k_ff] <= ev_rsp.value;
         tcm_pkg::ST_SORT: begin
            hi_ff  <= SORT_ROW(row, 0);
            mid_ff <= SORT_ROW(row, 1);
            lo_ff  <= SORT_ROW(row, 2);
         end
         tcm_pkg::ST_CHAN: begin
            if (ev_rsp.done) begin
               res_ff[k_ff] <= ev_rsp.value;
               // no ordering: blue copies the mapped green
               if (film_ff && (k_ff == 2'd1)) res_ff[2] <= ev_rsp.value;
            end
         end
         tcm_pkg::ST_ALPHA: if (ev_rsp.done) ares_ff <= ev_rsp.value;
         tcm_pkg::ST_FHI:   if (ev_rsp.done) res_ff[hi_ff] <= ev_rsp.value;
         tcm_pkg::ST_FLO: begin
            if (ev_rsp.done) begin
               res_ff[lo_ff] <= ev_rsp.value;
               if (ch_ff[hi_ff] == ch_ff[lo_ff]) res_ff[mid_ff] <= ev_rsp.value;
            end
         end
         tcm_pkg::ST_MID: if (ip_rsp.done) res_ff[mid_ff] <= ip_rsp.value;
         tcm_pkg::ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_r_ff <= res_ff[0];
               rsp_g_ff <= res_ff[1];
               rsp_b_ff <= res_ff[2];
               rsp_a_ff <= ares_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (paddr[4:2])
         tcm_pkg::REG_FILM_LIKE:    prdata = {31'b0, film_ff};
         tcm_pkg::REG_COUNT_MASTER: prdata = {23'b0, cnt_ff[0]};
         tcm_pkg::REG_COUNT_RED:    prdata = {23'b0, cnt_ff[1]};
         tcm_pkg::REG_COUNT_GREEN:  prdata = {23'b0, cnt_ff[2]};
         tcm_pkg::REG_COUNT_BLUE:   prdata = {23'b0, cnt_ff[3]};
         tcm_pkg::REG_COUNT_VALUE:  prdata = {23'b0, cnt_ff[4]};
         default:                   prdata = '0;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_r_ff;
   assign rsp_green_out = rsp_g_ff;
   assign rsp_blue_out  = rsp_b_ff;
   assign rsp_alpha_out = rsp_a_ff;

endmodule
